@@ hdl/alert_pulse_pattern_sequencer_top_assert.svh @@
// ---------------------------------------------------------------------------
// Assertion macros for the alert pulse pattern sequencer
// Concurrent checks sampled on clk and disabled while rst is high.
// ---------------------------------------------------------------------------
`ifndef ALERT_PULSE_PATTERN_SEQUENCER_TOP_ASSERT_SVH
`define ALERT_PULSE_PATTERN_SEQUENCER_TOP_ASSERT_SVH

// Same-cycle implication
`define APPS_ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication
`define APPS_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ hdl/apps_pkg.sv @@
// ---------------------------------------------------------------------------
// Alert pulse pattern sequencer package
// Transfer types, pattern codes and register indexes.
// ---------------------------------------------------------------------------
package apps_pkg;

  localparam int unsigned CfgWidth   = 15;
  localparam int unsigned CfgIdxW    = 3;
  localparam int unsigned TimerWidth = 16;

  // Register indexes on the configuration port
  typedef enum logic [CfgIdxW-1:0] {
    REG_CLICK_LEN = 3'd0,
    REG_PULSE_ON  = 3'd1,
    REG_MODE_GAP  = 3'd2,
    REG_FAULT_ON  = 3'd3,
    REG_FAULT_GAP = 3'd4
  } cfg_reg_t;

  // Item kinds
  localparam logic KIND_TICK  = 1'b0;
  localparam logic KIND_START = 1'b1;

  // Pattern selector codes of a start item
  localparam logic [2:0] SEL_NONE      = 3'd0;
  localparam logic [2:0] SEL_CLICK     = 3'd1;
  localparam logic [2:0] SEL_POWER_OFF = 3'd2;
  localparam logic [2:0] SEL_MODE      = 3'd3;
  localparam logic [2:0] SEL_FAULT     = 3'd4;

  // Number of pulses in the fault pattern
  localparam logic [1:0] FAULT_PULSES = 2'd3;

  // Running pattern, one-hot
  typedef enum logic [4:0] {
    PAT_NONE      = 5'b00001,
    PAT_CLICK     = 5'b00010,
    PAT_POWER_OFF = 5'b00100,
    PAT_MODE      = 5'b01000,
    PAT_FAULT     = 5'b10000
  } pat_state_t;

  typedef struct packed {
    logic                  kind;
    logic [2:0]            pattern_select;
    logic [TimerWidth-1:0] delta_ms;
  } in_item_t;

  typedef struct packed {
    logic drive_on;
    logic active;
  } out_item_t;

endpackage

@@ hdl/alert_pulse_pattern_sequencer_top.sv @@
// ---------------------------------------------------------------------------
// Alert pulse pattern sequencer
// Steps a buzzer/haptic enable through timed click, power-off, mode and
// fault pulse patterns, one result per input transfer.
// ---------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_stall/in_data): a start item loads a pattern
//   and clears timer and step; a tick item adds delta_ms to a running timer.
//   Output channel (out_valid/out_stall/out_data): one result per input item
//   carrying the drive level and the active flag, in input order.
//   Configuration: cfg_we writes cfg_data into register cfg_index (0 click
//   length, 1 pulse on, 2 mode gap, 3 fault on, 4 fault gap); other indexes
//   are dropped. Write only while no result is outstanding.
//   Result path: each result is registered in the output or skid register.
//   Throughput: one item per cycle while in_stall is low; the update is
//   adds, compares and a small case between state registers and the result.
//   Stall: a result held by out_stall stays in the output register; one more
//   item is taken into a skid register, after which in_stall rises until the
//   output drains.
//   Reset (rst, synchronous): no pattern, drive off, registers at defaults,
//   output and skid empty.
// ---------------------------------------------------------------------------
module alert_pulse_pattern_sequencer_top (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  apps_pkg::in_item_t              in_data,
  output logic                            out_valid,
  input  logic                            out_stall,
  output apps_pkg::out_item_t             out_data,
  input  logic                            cfg_we,
  input  logic [apps_pkg::CfgIdxW-1:0]    cfg_index,
  input  logic [apps_pkg::CfgWidth-1:0]   cfg_data
);
  import apps_pkg::*;

  `include "alert_pulse_pattern_sequencer_top_assert.svh"

  // Configuration registers
  logic [CfgWidth-1:0] click_len;
  logic [CfgWidth-1:0] pulse_on;
  logic [CfgWidth-1:0] mode_gap;
  logic [CfgWidth-1:0] fault_on;
  logic [CfgWidth-1:0] fault_gap;

  // Pattern state
  pat_state_t            pattern, pattern_next;
  logic [TimerWidth-1:0] pattern_timer, pattern_timer_next;
  logic [1:0]            pulse_step, pulse_step_next;
  logic                  drive_level, drive_level_next;

  // Output and skid registers
  out_item_t skid_data;
  logic      skid_valid;
  out_item_t result;

  logic in_fire;
  logic out_fire;

  logic [TimerWidth:0]   sum_wide;
  logic [TimerWidth-1:0] t_sat;
  logic [TimerWidth-1:0] mode_total;
  logic [TimerWidth-1:0] fault_total;
  logic [1:0]            step_inc;

  assign in_stall = skid_valid;
  assign in_fire  = in_valid && !skid_valid;
  assign out_fire = out_valid && !out_stall;

  // Write configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      click_len <= CfgWidth'(20);
      pulse_on  <= CfgWidth'(80);
      mode_gap  <= CfgWidth'(80);
      fault_on  <= CfgWidth'(150);
      fault_gap <= CfgWidth'(100);
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_CLICK_LEN: click_len <= cfg_data;
        REG_PULSE_ON:  pulse_on  <= cfg_data;
        REG_MODE_GAP:  mode_gap  <= cfg_data;
        REG_FAULT_ON:  fault_on  <= cfg_data;
        REG_FAULT_GAP: fault_gap <= cfg_data;
        default: ;
      endcase
    end
  end

  // Saturating timer add and pulse-plus-gap totals
  assign sum_wide    = {1'b0, pattern_timer} + {1'b0, in_data.delta_ms};
  assign t_sat       = sum_wide[TimerWidth] ? '1 : sum_wide[TimerWidth-1:0];
  assign mode_total  = {1'b0, pulse_on} + {1'b0, mode_gap};
  assign fault_total = {1'b0, fault_on} + {1'b0, fault_gap};
  assign step_inc    = pulse_step + 2'd1;

  // Compute the next pattern state for the incoming item
  always_comb begin
    pattern_next       = pattern;
    pattern_timer_next = pattern_timer;
    pulse_step_next    = pulse_step;
    drive_level_next   = drive_level;
    if (in_data.kind == KIND_START) begin
      pattern_timer_next = '0;
      pulse_step_next    = '0;
      unique case (in_data.pattern_select)
        SEL_CLICK:     pattern_next = PAT_CLICK;
        SEL_POWER_OFF: pattern_next = PAT_POWER_OFF;
        SEL_MODE:      pattern_next = PAT_MODE;
        SEL_FAULT:     pattern_next = PAT_FAULT;
        default:       pattern_next = PAT_NONE;
      endcase
    end else begin
      unique case (pattern)
        PAT_NONE: begin
          drive_level_next = 1'b0;
        end
        PAT_CLICK: begin
          pattern_timer_next = t_sat;
          drive_level_next   = (t_sat < {1'b0, click_len});
          if (t_sat >= {1'b0, click_len}) begin
            pattern_next = PAT_NONE;
          end
        end
        PAT_POWER_OFF: begin
          pattern_timer_next = t_sat;
          drive_level_next   = (t_sat < {1'b0, pulse_on});
          if (t_sat >= {1'b0, pulse_on}) begin
            pattern_next = PAT_NONE;
          end
        end
        PAT_MODE: begin
          pattern_timer_next = t_sat;
          drive_level_next   = (t_sat < {1'b0, pulse_on});
          if (pulse_step == 2'd0) begin
            if (t_sat >= mode_total) begin
              pulse_step_next    = 2'd1;
              pattern_timer_next = '0;
            end
          end else if (t_sat >= {1'b0, pulse_on}) begin
            pattern_next = PAT_NONE;
          end
        end
        PAT_FAULT: begin
          pattern_timer_next = t_sat;
          drive_level_next   = (t_sat < {1'b0, fault_on});
          if (t_sat >= fault_total) begin
            pattern_timer_next = '0;
            pulse_step_next    = step_inc;
            if (step_inc >= FAULT_PULSES) begin
              pattern_next = PAT_NONE;
            end
          end
        end
        default: begin
          pattern_next     = PAT_NONE;
          drive_level_next = 1'b0;
        end
      endcase
    end
  end

  assign result.drive_on = drive_level_next;
  assign result.active   = (pattern_next != PAT_NONE);

  // Advance pattern state on each input transfer
  always_ff @(posedge clk) begin
    if (rst) begin
      pattern       <= PAT_NONE;
      pattern_timer <= '0;
      pulse_step    <= '0;
      drive_level   <= 1'b0;
    end else if (in_fire) begin
      pattern       <= pattern_next;
      pattern_timer <= pattern_timer_next;
      pulse_step    <= pulse_step_next;
      drive_level   <= drive_level_next;
    end
  end

  // Output register with one skid entry
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (out_fire || !out_valid) begin
      if (skid_valid) begin
        out_valid  <= 1'b1;
        skid_valid <= 1'b0;
      end else begin
        out_valid <= in_fire;
      end
    end else if (in_fire) begin
      skid_valid <= 1'b1;
    end
  end

  // Move payloads; no reset needed
  always_ff @(posedge clk) begin
    if (out_fire || !out_valid) begin
      if (skid_valid) begin
        out_data <= skid_data;
      end else if (in_fire) begin
        out_data <= result;
      end
    end else if (in_fire) begin
      skid_data <= result;
    end
  end

  `APPS_ASSERT_IMPL(a_skid_needs_out, skid_valid, out_valid, "skid holds data while output empty")
  `APPS_ASSERT_NEXT(a_stall_to_skid, in_fire && out_valid && out_stall, skid_valid, "held result overwritten")
  `APPS_ASSERT_NEXT(a_start_clears, in_fire && in_data.kind == KIND_START, pattern_timer == '0 && pulse_step == '0, "start did not clear timer")
  `APPS_ASSERT_IMPL(a_mode_step, pattern == PAT_MODE, pulse_step <= 2'd1, "mode pattern step out of range")
  `APPS_ASSERT_IMPL(a_fault_step, pattern == PAT_FAULT, pulse_step < FAULT_PULSES, "fault pattern step out of range")

endmodule
